>>> src/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

    localparam int unsigned EXP_DEPTH_DEF = 1024;
    localparam int unsigned AMP_FRAC_BITS = 15;
    localparam int unsigned TIME_W        = 24;
    localparam int unsigned SUS_W         = 16;
    localparam int unsigned AMP_W         = 16;
    localparam int unsigned IN_W          = 32;
    localparam int unsigned NUM_W         = 53;
    localparam int unsigned EXP_W         = 31;
    localparam int unsigned POS_FRAC_W    = 16;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 24;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [SUS_W-1:0] AMP_ONE = SUS_W'(1 << AMP_FRAC_BITS);

    localparam logic [TIME_W-1:0] RST_ATTACK  = 24'd5000;
    localparam logic [TIME_W-1:0] RST_DECAY   = 24'd100000;
    localparam logic [SUS_W-1:0]  RST_SUSTAIN = 16'd22938;
    localparam logic [TIME_W-1:0] RST_RELEASE = 24'd300000;

    typedef enum logic [1:0] {
        CFG_ATTACK,
        CFG_DECAY,
        CFG_SUSTAIN,
        CFG_RELEASE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_HELD,
        MODE_RELEASE,
        MODE_SILENT
    } t_mode;

    typedef enum logic [1:0] {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_SUSTAIN
    } t_seg;

    typedef struct packed {
        logic [TIME_W-1:0] attack;
        logic [TIME_W-1:0] decay;
        logic [SUS_W-1:0]  sustain;
        logic [TIME_W-1:0] release_t;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        t_seg              seg;
        logic [SUS_W-1:0]  sus;
        logic [NUM_W-1:0]  num_s;
        logic [TIME_W-1:0] den_s;
        logic [NUM_W-1:0]  num_r;
        logic [TIME_W-1:0] den_r;
    } t_job;

    typedef struct packed {
        t_seg             seg;
        logic [SUS_W-1:0] sus;
    } t_side;

endpackage

`default_nettype wire

>>> src/adsr_queue.sv
`default_nettype none

module adsr_queue import adsr_pkg::*; #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_nonempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("Queue read while empty.");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("Queue count did not follow a push.");
`endif

endmodule

`default_nettype wire

>>> src/adsr_front.sv
`default_nettype none

module adsr_front import adsr_pkg::*; #(
    parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cfg            i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [IN_W-1:0] i_press_elapsed,
    input  wire logic            i_note_held,
    input  wire logic [IN_W-1:0] i_release_elapsed,
    output logic                 o_push,
    output t_job                 o_job,
    input  wire logic            i_full
);

    localparam int unsigned PROD_W = SUS_W + TIME_W;

    logic              w_adv1, w_adv2;
    logic [IN_W-2:0]   w_p, w_r;
    logic [TIME_W:0]   w_ad;
    t_seg              n1_seg;
    t_mode             n1_mode;
    logic [SUS_W-1:0]  n1_sus;

    logic              r1_v;
    logic [TIME_W-1:0] r1_p, r1_r, r1_pa;
    t_seg              r1_seg;
    t_mode             r1_mode;
    logic [SUS_W-1:0]  r1_sus;

    logic [PROD_W-1:0] w_prod;
    t_job              n2_job;
    logic              r2_v;
    t_job              r2_job;

    assign w_adv2  = !r2_v || !i_full;
    assign w_adv1  = !r1_v || w_adv2;
    assign o_ready = w_adv1;
    assign o_push  = r2_v && !i_full;
    assign o_job   = r2_job;

    always_comb begin
        w_p  = i_press_elapsed[IN_W-1] ? '0 : i_press_elapsed[IN_W-2:0];
        w_r  = i_release_elapsed[IN_W-1] ? '0 : i_release_elapsed[IN_W-2:0];
        w_ad = {1'b0, i_cfg.attack} + {1'b0, i_cfg.decay};
        priority if (w_p < (IN_W-1)'(i_cfg.attack)) begin
            n1_seg = SEG_ATTACK;
        end else if (w_p < (IN_W-1)'(w_ad)) begin
            n1_seg = SEG_DECAY;
        end else begin
            n1_seg = SEG_SUSTAIN;
        end
        priority if (i_note_held) begin
            n1_mode = MODE_HELD;
        end else if (i_cfg.release_t == '0 || w_r >= (IN_W-1)'(i_cfg.release_t)) begin
            n1_mode = MODE_SILENT;
        end else begin
            n1_mode = MODE_RELEASE;
        end
        n1_sus = (i_cfg.sustain > AMP_ONE) ? AMP_ONE : i_cfg.sustain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_p    <= w_p[TIME_W-1:0];
            r1_r    <= w_r[TIME_W-1:0];
            r1_pa   <= w_p[TIME_W-1:0] - i_cfg.attack;
            r1_seg  <= n1_seg;
            r1_mode <= n1_mode;
            r1_sus  <= n1_sus;
        end
    end

    always_comb begin
        w_prod       = (AMP_ONE - r1_sus) * r1_pa;
        n2_job.mode  = r1_mode;
        n2_job.seg   = r1_seg;
        n2_job.sus   = r1_sus;
        n2_job.den_r = i_cfg.release_t;
        n2_job.num_r = (NUM_W'(r1_r) * NUM_W'(EXP_TABLE_DEPTH)) << POS_FRAC_W;
        unique case (r1_seg)
            SEG_ATTACK: begin
                n2_job.num_s = NUM_W'(r1_p) << AMP_FRAC_BITS;
                n2_job.den_s = i_cfg.attack;
            end
            SEG_DECAY: begin
                n2_job.num_s = NUM_W'(w_prod);
                n2_job.den_s = i_cfg.decay;
            end
            default: begin
                n2_job.num_s = '0;
                n2_job.den_s = i_cfg.decay;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_job <= n2_job;
        end
    end

endmodule

`default_nettype wire

>>> src/adsr_div.sv
`default_nettype none

module adsr_div import adsr_pkg::*; #(
    parameter int unsigned QW = 26,
    parameter int unsigned DW = TIME_W,
    parameter int unsigned PW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [DW+QW-1:0] i_num,
    input  wire logic [DW-1:0]   i_den,
    input  wire logic [PW-1:0]   i_pay,
    output logic [QW-1:0]        o_quo,
    output logic [PW-1:0]        o_pay
);

    logic [DW-1:0] w_rem [QW+1];
    logic [QW-1:0] w_low [QW+1];
    logic [QW-1:0] w_quo [QW+1];
    logic [DW-1:0] w_den [QW+1];
    logic [PW-1:0] w_pay [QW+1];

    assign w_rem[0] = i_num[DW+QW-1:QW];
    assign w_low[0] = i_num[QW-1:0];
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_pay[0] = i_pay;

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [DW:0]   w_t;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [DW-1:0] r_rem, r_den;
        logic [QW-1:0] r_low, r_quo;
        logic [PW-1:0] r_pay;

        always_comb begin
            w_t   = {w_rem[j], w_low[j][QW-1]};
            w_ge  = (w_t >= {1'b0, w_den[j]});
            n_rem = w_ge ? DW'(w_t - {1'b0, w_den[j]}) : w_t[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_low <= w_low[j] << 1;
                r_quo <= {w_quo[j][QW-2:0], w_ge};
                r_den <= w_den[j];
                r_pay <= w_pay[j];
            end
        end

        assign w_rem[j+1] = r_rem;
        assign w_low[j+1] = r_low;
        assign w_quo[j+1] = r_quo;
        assign w_den[j+1] = r_den;
        assign w_pay[j+1] = r_pay;
    end

    assign o_quo = w_quo[QW];
    assign o_pay = w_pay[QW];

endmodule

`default_nettype wire

>>> src/adsr_back.sv
`default_nettype none

module adsr_back import adsr_pkg::*; #(
    parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_nonempty,
    output logic             o_pop,
    input  wire t_job        i_job,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [AMP_W-1:0] o_amplitude
);

    localparam int unsigned QW    = $clog2(EXP_TABLE_DEPTH) + POS_FRAC_W;
    localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int unsigned SIDE_W = $bits(t_side);
    localparam int unsigned MODE_W = $bits(t_mode);

    typedef logic [EXP_W-1:0] t_rom [EXP_TABLE_DEPTH + 1];

    function automatic longint unsigned div_small(input longint unsigned n,
                                                  input longint unsigned d);
        longint unsigned q, rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [EXP_W-1:0] exp_point(input longint unsigned i);
        longint unsigned u, term, a;
        longint          sum;
        logic            done;
        u    = (i << 28) / EXP_TABLE_DEPTH;
        sum  = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                term = div_small((term * u) >> 30, longint'(k));
                if (term == 0) begin
                    done = 1'b1;
                end else if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        a = (sum > 0) ? longint'(sum) : 0;
        for (int s = 0; s < 4; s++) begin
            a = (a * a + (64'd1 << 29)) >> 30;
        end
        return EXP_W'(a);
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= int'(EXP_TABLE_DEPTH); i++) begin
            rom[i] = exp_point(longint'(i));
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    logic              w_adv;
    logic [QW-1:0]     r_vq;
    t_side             w_side_in, w_side;
    logic [MODE_W-1:0] w_mode_bits;
    logic [QW-1:0]     w_qs, w_qr;
    logic [SUS_W-1:0]  n1_start;

    logic                 r1_v, r2_v, r3_v, r4_v, r_out_v;
    t_mode                r1_mode, r2_mode, r3_mode, r4_mode;
    logic [SUS_W-1:0]     r1_start, r2_start, r3_start, r4_start;
    logic [IDX_W-1:0]     r1_idx;
    logic [POS_FRAC_W-1:0] r1_f, r2_f;
    logic [EXP_W-1:0]     r2_hi, r2_lo, r3_hi, r3_dl, r4_e;
    logic [EXP_W-1:0]     w_diff;
    logic [EXP_W+POS_FRAC_W-1:0] w_dprod;
    logic [SUS_W+EXP_W-1:0]      w_aprod;
    logic [AMP_W-1:0]     n_amp, r_amp;

    assign w_adv       = !r_out_v || i_ready;
    assign o_pop       = w_adv && i_nonempty;
    assign o_valid     = r_out_v;
    assign o_amplitude = r_amp;

    assign w_side_in.seg = i_job.seg;
    assign w_side_in.sus = i_job.sus;

    adsr_div #(.QW(QW), .DW(TIME_W), .PW(SIDE_W)) u_div_start (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (i_job.num_s[TIME_W+QW-1:0]),
        .i_den (i_job.den_s),
        .i_pay (w_side_in),
        .o_quo (w_qs),
        .o_pay (w_side)
    );

    adsr_div #(.QW(QW), .DW(TIME_W), .PW(MODE_W)) u_div_pos (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (i_job.num_r[TIME_W+QW-1:0]),
        .i_den (i_job.den_r),
        .i_pay (i_job.mode),
        .o_quo (w_qr),
        .o_pay (w_mode_bits)
    );

    always_comb begin
        unique case (w_side.seg)
            SEG_ATTACK: n1_start = w_qs[SUS_W-1:0];
            SEG_DECAY:  n1_start = AMP_ONE - w_qs[SUS_W-1:0];
            default:    n1_start = w_side.sus;
        endcase
        w_diff  = (r2_hi >= r2_lo) ? r2_hi - r2_lo : '0;
        w_dprod = w_diff * r2_f;
        w_aprod = r4_start * r4_e;
        unique case (r4_mode)
            MODE_HELD:    n_amp = r4_start;
            MODE_RELEASE: n_amp = w_aprod[30 +: AMP_W];
            default:      n_amp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq    <= '0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_vq    <= {r_vq[QW-2:0], i_nonempty};
            r1_v    <= r_vq[QW-1];
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_out_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mode  <= t_mode'(w_mode_bits);
            r1_start <= n1_start;
            r1_idx   <= IDX_W'(w_qr[QW-1:POS_FRAC_W]);
            r1_f     <= w_qr[POS_FRAC_W-1:0];

            r2_mode  <= r1_mode;
            r2_start <= r1_start;
            r2_f     <= r1_f;
            r2_hi    <= EXP_ROM[r1_idx];
            r2_lo    <= EXP_ROM[r1_idx + IDX_W'(1)];

            r3_mode  <= r2_mode;
            r3_start <= r2_start;
            r3_hi    <= r2_hi;
            r3_dl    <= w_dprod[POS_FRAC_W +: EXP_W];

            r4_mode  <= r3_mode;
            r4_start <= r3_start;
            r4_e     <= r3_hi - r3_dl;

            r_amp    <= n_amp;
        end
    end

endmodule

`default_nettype wire

>>> src/adsr_envelope_amplitude.sv
// Pipeline: the two front stages, the queue, ceil(log2(EXP_TABLE_DEPTH))+16 divider stages
// and five back stages.
// Throughput: one transaction per cycle while i_ready does not stall the output, set by the
// pipelined restoring dividers that resolve one quotient bit per stage.
// Reset is synchronous and active low; it empties the pipeline and queue and loads the
// default register values.
`default_nettype none

module adsr_envelope_amplitude import adsr_pkg::*; #(
    parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [IN_W-1:0]       i_press_elapsed,
    input  wire logic                  i_note_held,
    input  wire logic [IN_W-1:0]       i_release_elapsed,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [AMP_W-1:0]           o_amplitude
);

    localparam int unsigned JOB_W = $bits(t_job);

    t_cfg             r_cfg;
    logic             w_push, w_pop, w_full, w_nonempty;
    t_job             w_job_in, w_job_out;
    logic [JOB_W-1:0] w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack    <= RST_ATTACK;
            r_cfg.decay     <= RST_DECAY;
            r_cfg.sustain   <= RST_SUSTAIN;
            r_cfg.release_t <= RST_RELEASE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ATTACK:  r_cfg.attack    <= i_cfg_data[TIME_W-1:0];
                CFG_DECAY:   r_cfg.decay     <= i_cfg_data[TIME_W-1:0];
                CFG_SUSTAIN: r_cfg.sustain   <= i_cfg_data[SUS_W-1:0];
                CFG_RELEASE: r_cfg.release_t <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    adsr_front #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_press_elapsed   (i_press_elapsed),
        .i_note_held       (i_note_held),
        .i_release_elapsed (i_release_elapsed),
        .o_push            (w_push),
        .o_job             (w_job_in),
        .i_full            (w_full)
    );

    adsr_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_job_in),
        .i_pop      (w_pop),
        .o_data     (w_q_data),
        .o_full     (w_full),
        .o_nonempty (w_nonempty)
    );

    assign w_job_out = t_job'(w_q_data);

    adsr_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (w_nonempty),
        .o_pop       (w_pop),
        .i_job       (w_job_out),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_amplitude (o_amplitude)
    );

endmodule

`default_nettype wire
